/* hw/rtl/trce_pkg.sv */
`timescale 1ns / 1ps

package trce_pkg;

    localparam int WORD_W     = 16;
    localparam int DATA_W     = 32;
    localparam int REG_ADDR_W = 4;
    localparam int NUM_REGS   = 16;
    localparam int IMM_W      = 8;
    localparam int OPC_W      = 4;

    localparam logic [REG_ADDR_W-1:0] PC_INDEX = 4'd15;
    localparam logic [DATA_W-1:0]     PC_STEP  = 32'd4;

    localparam logic [OPC_W-1:0] OPC_LOAD  = 4'd1;
    localparam logic [OPC_W-1:0] OPC_ADD   = 4'd2;
    localparam logic [OPC_W-1:0] OPC_SUB   = 4'd3;
    localparam logic [OPC_W-1:0] OPC_PRINT = 4'd4;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;

    localparam int OUT_DATA_W = 72;

    typedef enum logic [2:0] {
        KIND_LOAD,
        KIND_ADD,
        KIND_SUB,
        KIND_PRINT,
        KIND_HALT
    } op_kind_t;

    typedef struct packed {
        op_kind_t                kind;
        logic [REG_ADDR_W-1:0]   ra;
        logic [REG_ADDR_W-1:0]   rb;
        logic [REG_ADDR_W-1:0]   rc;
        logic [IMM_W-1:0]        imm;
    } uop_t;

    typedef struct packed {
        logic [DATA_W-1:0] fetch_address;
        logic              print_valid;
        logic [DATA_W-1:0] print_value;
        logic              halted;
    } result_t;

endpackage

/* hw/rtl/trce_front.sv */
`timescale 1ns / 1ps

module trce_front (
    input  logic [trce_pkg::WORD_W-1:0] instruction_word,
    output trce_pkg::uop_t              uop
);
    import trce_pkg::*;

    logic [OPC_W-1:0] opcode;

    assign opcode = instruction_word[15:12];

    always_comb begin
        uop.ra  = instruction_word[11:8];
        uop.rb  = instruction_word[7:4];
        uop.rc  = instruction_word[3:0];
        uop.imm = instruction_word[7:0];
        case (opcode)
            OPC_LOAD:  uop.kind = KIND_LOAD;
            OPC_ADD:   uop.kind = KIND_ADD;
            OPC_SUB:   uop.kind = KIND_SUB;
            OPC_PRINT: uop.kind = KIND_PRINT;
            default:   uop.kind = KIND_HALT;
        endcase
    end

endmodule

/* hw/rtl/trce_queue.sv */
`timescale 1ns / 1ps

module trce_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  trce_pkg::uop_t in_uop,
    output logic           out_valid,
    input  logic           out_ready,
    output trce_pkg::uop_t out_uop
);
    import trce_pkg::*;

    uop_t                   slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                   push, pop;

    assign in_ready  = (count_reg != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_uop   = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_uop;
        end
    end

endmodule

/* hw/rtl/trce_back.sv */
`timescale 1ns / 1ps

module trce_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              uop_valid,
    output logic              uop_ready,
    input  trce_pkg::uop_t    uop,
    output logic              res_valid,
    input  logic              res_ready,
    output trce_pkg::result_t res
);
    import trce_pkg::*;

    // General registers; the program counter lives in its own flip-flops.
    logic [DATA_W-1:0]     rf_mem [NUM_REGS];
    logic [NUM_REGS-1:0]   rf_vld_reg, rf_vld_next;

    uop_t                  ex_uop_reg;
    logic                  ex_valid_reg, ex_valid_next;
    logic [REG_ADDR_W-1:0] ex_addr_a_reg;
    logic [DATA_W-1:0]     rd_a_reg, rd_b_reg;
    logic                  vld_a_reg, vld_b_reg;
    logic                  byp_a_reg, byp_b_reg;
    logic [DATA_W-1:0]     byp_data_reg;

    logic [DATA_W-1:0]     pc_reg, pc_next;
    logic                  halt_reg, halt_next;
    logic                  res_valid_reg, res_valid_next;
    result_t               res_reg, res_next;

    logic [REG_ADDR_W-1:0] head_addr_a;
    logic                  fire, ex_load;
    logic [DATA_W-1:0]     pc_adv, op_a, op_b;
    logic                  wr_en, mem_we;
    logic [DATA_W-1:0]     wr_data;

    assign fire      = ex_valid_reg && (!res_valid_reg || res_ready);
    assign ex_load   = !ex_valid_reg || fire;
    assign uop_ready = ex_load;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    assign head_addr_a = (uop.kind == KIND_PRINT) ? uop.ra : uop.rb;

    // Operand select: program counter, same-edge write, stored value, or reset zero.
    assign pc_adv = pc_reg + PC_STEP;

    always_comb begin
        if (ex_addr_a_reg == PC_INDEX) begin
            op_a = pc_adv;
        end else if (byp_a_reg) begin
            op_a = byp_data_reg;
        end else if (vld_a_reg) begin
            op_a = rd_a_reg;
        end else begin
            op_a = '0;
        end
        if (ex_uop_reg.rc == PC_INDEX) begin
            op_b = pc_adv;
        end else if (byp_b_reg) begin
            op_b = byp_data_reg;
        end else if (vld_b_reg) begin
            op_b = rd_b_reg;
        end else begin
            op_b = '0;
        end
    end

    always_comb begin
        wr_en                  = 1'b0;
        wr_data                = '0;
        halt_next              = halt_reg;
        pc_next                = pc_reg;
        res_next               = res_reg;
        ex_valid_next          = ex_load ? uop_valid : ex_valid_reg;
        res_valid_next         = res_valid_reg && !res_ready;
        if (fire) begin
            res_valid_next        = 1'b1;
            res_next.print_valid  = 1'b0;
            res_next.print_value  = '0;
            if (!halt_reg) begin
                case (ex_uop_reg.kind)
                    KIND_LOAD: begin
                        wr_en   = 1'b1;
                        wr_data = {{(DATA_W-IMM_W){1'b0}}, ex_uop_reg.imm};
                    end
                    KIND_ADD: begin
                        wr_en   = 1'b1;
                        wr_data = op_a + op_b;
                    end
                    KIND_SUB: begin
                        wr_en   = 1'b1;
                        wr_data = op_a - op_b;
                    end
                    KIND_PRINT: begin
                        res_next.print_valid = 1'b1;
                        res_next.print_value = op_a;
                    end
                    default: begin
                        halt_next = 1'b1;
                    end
                endcase
                pc_next = (wr_en && ex_uop_reg.ra == PC_INDEX) ? wr_data : pc_adv;
            end
            res_next.fetch_address = pc_next;
            res_next.halted        = halt_next;
        end
    end

    assign mem_we = wr_en && (ex_uop_reg.ra != PC_INDEX);

    always_comb begin
        rf_vld_next = rf_vld_reg;
        if (mem_we) begin
            rf_vld_next[ex_uop_reg.ra] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rf_vld_reg    <= '0;
            ex_valid_reg  <= 1'b0;
            pc_reg        <= '0;
            halt_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            rf_vld_reg    <= rf_vld_next;
            ex_valid_reg  <= ex_valid_next;
            pc_reg        <= pc_next;
            halt_reg      <= halt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
        if (mem_we) begin
            rf_mem[ex_uop_reg.ra] <= wr_data;
        end
        if (ex_load) begin
            ex_uop_reg    <= uop;
            ex_addr_a_reg <= head_addr_a;
            rd_a_reg      <= rf_mem[head_addr_a];
            rd_b_reg      <= rf_mem[uop.rc];
            vld_a_reg     <= rf_vld_reg[head_addr_a];
            vld_b_reg     <= rf_vld_reg[uop.rc];
            byp_a_reg     <= mem_we && (ex_uop_reg.ra == head_addr_a);
            byp_b_reg     <= mem_we && (ex_uop_reg.ra == uop.rc);
            byp_data_reg  <= wr_data;
        end
    end

endmodule

/* hw/rtl/tiny_register_cpu_execute.sv */
`timescale 1ns / 1ps

// Channel   Direction  Width  Contents
// s_axis    in         16     instruction_word
// m_axis    out        72     fetch_address, print_valid, print_value, halted
//
// One instruction per cycle when the result side keeps up; the path is
// decode, a two-entry queue, an operand read stage and an execute stage
// with a registered output. Reset clears the program counter, the halt flag
// and the valid flags of all sixteen registers.
// A stall on m_axis holds the execute stage and fills the queue before s_tready drops.

module tiny_register_cpu_execute (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [trce_pkg::WORD_W-1:0]     s_tdata,  // [15:0] instruction_word
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [31:0] fetch_address, [32] print_valid, [64:33] print_value, [65] halted
    output logic [trce_pkg::OUT_DATA_W-1:0] m_tdata
);
    import trce_pkg::*;

    uop_t    dec_uop;
    uop_t    q_uop;
    logic    q_valid, q_ready;
    result_t res;

    trce_front u_front (
        .instruction_word (s_tdata),
        .uop              (dec_uop)
    );

    trce_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_uop    (dec_uop),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_uop   (q_uop)
    );

    trce_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .uop_valid (q_valid),
        .uop_ready (q_ready),
        .uop       (q_uop),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    assign m_tdata = {6'b0, res.halted, res.print_value, res.print_valid, res.fetch_address};

endmodule
